FILE: rtl/core/ppfp_pkg.sv
package ppfp_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_IDX_W       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ADDR_W     = 28;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CfgRedMask   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CfgGreenMask = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CfgBlueMask  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CfgAlphaMask = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CfgWide      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CfgPaletted  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CfgPitch     = 3'd6;

  // Byte count codes
  localparam logic [1:0] Count1Byte = 2'd0;
  localparam logic [1:0] Count2Byte = 2'd1;
  localparam logic [1:0] Count4Byte = 2'd2;

  // Input function codes
  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncPixel = 1'b1;

  typedef struct packed {
    logic [31:0] mask;
    logic [4:0]  shift;
  } chan_cfg_t;

  typedef struct packed {
    chan_cfg_t   red;
    chan_cfg_t   green;
    chan_cfg_t   blue;
    chan_cfg_t   alpha;
    logic        wide;
    logic        paletted;
    logic [15:0] pitch;
  } fmt_cfg_t;

  typedef struct packed {
    logic [7:0]  entry;
    logic [7:0]  alpha;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic        in_range;
  } pix_req_t;

endpackage

FILE: rtl/core/ppfp_cfg.sv
module ppfp_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ppfp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ppfp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output ppfp_pkg::fmt_cfg_t                   cfg_o
);
  import ppfp_pkg::*;

  // Leading zero count by halving; a zero mask gives a don't-care shift.
  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [31:0] w;
    logic [4:0]  n;
    w = v;
    n = '0;
    if (w[31:16] == '0) begin n[4] = 1'b1; w = {w[15:0], 16'b0}; end
    if (w[31:24] == '0) begin n[3] = 1'b1; w = {w[23:0], 8'b0}; end
    if (w[31:28] == '0) begin n[2] = 1'b1; w = {w[27:0], 4'b0}; end
    if (w[31:30] == '0) begin n[1] = 1'b1; w = {w[29:0], 2'b0}; end
    if (w[31] == 1'b0) begin n[0] = 1'b1; end
    return n;
  endfunction

  fmt_cfg_t  cfg_q, cfg_d;
  chan_cfg_t wr_chan;

  assign wr_chan.mask  = cfg_wdata_i;
  assign wr_chan.shift = lzc32(cfg_wdata_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRedMask:   cfg_d.red      = wr_chan;
        CfgGreenMask: cfg_d.green    = wr_chan;
        CfgBlueMask:  cfg_d.blue     = wr_chan;
        CfgAlphaMask: cfg_d.alpha    = wr_chan;
        CfgWide:      cfg_d.wide     = cfg_wdata_i[0];
        CfgPaletted:  cfg_d.paletted = cfg_wdata_i[0];
        CfgPitch:     cfg_d.pitch    = cfg_wdata_i[15:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/ppfp_palette.sv
module ppfp_palette (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [ppfp_pkg::PAL_IDX_W-1:0] waddr_i,
  input  logic [23:0]                    wdata_i,
  input  logic                           re_i,
  input  logic [ppfp_pkg::PAL_IDX_W-1:0] raddr_i,
  output logic [23:0]                    rdata_o
);
  import ppfp_pkg::*;

  logic [23:0] mem_q [PALETTE_ENTRIES];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ppfp_pack.sv
module ppfp_pack (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  ppfp_pkg::pix_req_t              req_i,
  input  logic [23:0]                     rgb_i,
  input  ppfp_pkg::fmt_cfg_t              cfg_i,
  output logic                            valid_o,
  output logic [ppfp_pkg::ADDR_W-1:0]     byte_address_o,
  output logic [31:0]                     pixel_data_o,
  output logic [1:0]                      byte_count_o
);
  import ppfp_pkg::*;

  // Byte to the top of the word, move down to the field's top bit, keep the field.
  function automatic logic [31:0] pack_chan(input logic [7:0] b, input chan_cfg_t c);
    logic [31:0] placed;
    placed = {b, 24'b0} >> c.shift;
    return placed & c.mask;
  endfunction

  logic [23:0]        rgb;
  logic [31:0]        colour;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  col_off;
  logic               valid_q;
  logic [ADDR_W-1:0]  addr_d, addr_q;
  logic [31:0]        data_d, data_q;
  logic [1:0]         count_d, count_q;

  assign rgb    = req_i.in_range ? rgb_i : 24'h0;
  assign colour = pack_chan(rgb[23:16], cfg_i.red)
                | pack_chan(rgb[15:8], cfg_i.green)
                | pack_chan(rgb[7:0], cfg_i.blue)
                | pack_chan(req_i.alpha, cfg_i.alpha);
  assign base   = ADDR_W'(cfg_i.pitch) * ADDR_W'(req_i.pos_y);

  always_comb begin
    if (cfg_i.paletted) begin
      col_off = ADDR_W'(req_i.pos_x);
      data_d  = {24'h0, req_i.entry};
      count_d = Count1Byte;
    end else if (cfg_i.wide) begin
      col_off = ADDR_W'({req_i.pos_x, 2'b00});
      data_d  = colour;
      count_d = Count4Byte;
    end else begin
      col_off = ADDR_W'({req_i.pos_x, 1'b0});
      data_d  = {16'h0, colour[15:0]};
      count_d = Count2Byte;
    end
    addr_d = base + col_off;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      addr_q  <= addr_d;
      data_q  <= data_d;
      count_q <= count_d;
    end
  end

  assign valid_o        = valid_q;
  assign byte_address_o = addr_q;
  assign pixel_data_o   = data_q;
  assign byte_count_o   = count_q;

endmodule

FILE: rtl/core/palette_pixel_format_packer_top.sv
// A pixel request is registered with its palette read, then packed and registered;
// result_valid_o marks the result for one cycle. Loads give no result.
// Throughput: one request per cycle, set by the single palette read port and
// the pack/address stage behind it; busy_o stays low and the receiver cannot stall.
// Reset: rst_ni clears the format registers and pipeline valid bits; palette
// contents are undefined until loaded.
module palette_pixel_format_packer_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 func_i,
  input  logic [7:0]                           entry_i,
  input  logic [7:0]                           red_in_i,
  input  logic [7:0]                           green_in_i,
  input  logic [7:0]                           blue_in_i,
  input  logic [11:0]                          pos_x_i,
  input  logic [11:0]                          pos_y_i,
  input  logic [7:0]                           alpha_in_i,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [ppfp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ppfp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // result channel
  output logic                                 result_valid_o,
  output logic [ppfp_pkg::ADDR_W-1:0]          byte_address_o,
  output logic [31:0]                          pixel_data_o,
  output logic [1:0]                           byte_count_o
);
  import ppfp_pkg::*;

  fmt_cfg_t cfg;
  logic     accept;
  logic     in_range;
  logic     load_we;
  logic     pix_re;
  logic     s1_valid_q;
  pix_req_t s1_req_q, s1_req_d;
  logic [23:0] rgb;

  // Never stall: every request is taken as it arrives.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Slot range check against the palette depth.
  assign in_range = (32'(entry_i) < PALETTE_ENTRIES);

  // Loads write the palette at the accept edge, pixels read it at the same edge.
  // A pixel right after a load of its slot reads after the write edge, so it already
  // sees the new colour: no forwarding path is needed.
  assign load_we = accept && (func_i == FuncLoad) && in_range;
  assign pix_re  = accept && (func_i == FuncPixel);

  ppfp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  ppfp_palette u_palette (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(entry_i[PAL_IDX_W-1:0]),
    .wdata_i({red_in_i, green_in_i, blue_in_i}),
    .re_i   (pix_re),
    .raddr_i(entry_i[PAL_IDX_W-1:0]),
    .rdata_o(rgb)
  );

  // Hold the pixel request alongside the palette read.
  always_comb begin
    s1_req_d.entry    = entry_i;
    s1_req_d.alpha    = alpha_in_i;
    s1_req_d.pos_x    = pos_x_i;
    s1_req_d.pos_y    = pos_y_i;
    s1_req_d.in_range = in_range;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pix_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_re) begin
      s1_req_q <= s1_req_d;
    end
  end

  // Pack colour, compute address and register the result.
  ppfp_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s1_valid_q),
    .req_i         (s1_req_q),
    .rgb_i         (rgb),
    .cfg_i         (cfg),
    .valid_o       (result_valid_o),
    .byte_address_o(byte_address_o),
    .pixel_data_o  (pixel_data_o),
    .byte_count_o  (byte_count_o)
  );

  // A result only ever follows a pixel request, through the palette read and pack registers.
  a_result_from_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && (func_i == FuncPixel), 2))
    else $error("result without a pixel request");

  // A load never produces a result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && (func_i == FuncLoad)) |-> ##2 !result_valid_o)
    else $error("load produced a result");

  // Paletted results are single bytes holding the index.
  a_paletted_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && cfg.paletted) |->
      (byte_count_o == Count1Byte) && (pixel_data_o[31:8] == '0))
    else $error("paletted result is not a single index byte");

endmodule
